// ===== hw/rtl/fra_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and operation codes for the fraction arithmetic block.
package fra_pkg;

    localparam int OP_WIDTH    = 2;
    localparam int DEN_WIDTH   = 15;
    localparam int PROD_WIDTH  = 30;
    localparam int WHOLE_WIDTH = 31;
    localparam int FNUM_WIDTH  = 32;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

endpackage

// ===== hw/rtl/fra_in_if.sv =====
`timescale 1ns / 1ps
// Operand channel: two fractions and an operation code.
interface fra_in_if
    import fra_pkg::*;
#(
    parameter int FRACTION_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic [OP_WIDTH-1:0]              op;
    logic signed [FRACTION_WIDTH-1:0] a_num;
    logic [DEN_WIDTH-1:0]             a_den;
    logic signed [FRACTION_WIDTH-1:0] b_num;
    logic [DEN_WIDTH-1:0]             b_den;

    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== hw/rtl/fra_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: whole part and reduced remaining fraction.
interface fra_out_if
    import fra_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [WHOLE_WIDTH-1:0]       whole_part;
    logic signed [FNUM_WIDTH-1:0] frac_num;
    logic [PROD_WIDTH-1:0]        frac_den;

    modport source (output valid, whole_part, frac_num, frac_den, input ready);
    modport sink   (input valid, whole_part, frac_num, frac_den, output ready);
endinterface

// ===== hw/rtl/fra_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module fra_mul
#(
    parameter int OPND_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic signed [OPND_WIDTH-1:0]   mul_a,
    input  logic signed [OPND_WIDTH-1:0]   mul_b,
    output logic signed [2*OPND_WIDTH-1:0] product
);

    logic signed [2*OPND_WIDTH-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= mul_a * mul_b;
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/fra_div.sv =====
`timescale 1ns / 1ps
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module fra_div
#(
    parameter int NUM_WIDTH = 33,
    parameter int DIV_WIDTH = 30
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] quotient,
    output logic [DIV_WIDTH-1:0] remainder
);

    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0] quo_reg;
    logic [DIV_WIDTH-1:0] rem_reg;
    logic [DIV_WIDTH-1:0] dsr_reg;

    logic [DIV_WIDTH:0]   rem_shift;
    logic [DIV_WIDTH:0]   rem_sub;
    logic                 fits;

    // shift in the next dividend bit, subtract where the divisor fits
    assign rem_shift = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(NUM_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_WIDTH-2:0], fits};
            rem_reg <= fits ? rem_sub[DIV_WIDTH-1:0] : rem_shift[DIV_WIDTH-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/fra_gcd.sv =====
`timescale 1ns / 1ps
// Binary gcd of two nonzero values, one shift or subtract per cycle.
module fra_gcd
#(
    parameter int NUM_WIDTH = 33,
    parameter int DIV_WIDTH = 30
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] x,
    input  logic [NUM_WIDTH-1:0] y,
    output logic                 done,
    output logic [DIV_WIDTH-1:0] g
);

    localparam int K_WIDTH = $clog2(NUM_WIDTH + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NUM_WIDTH-1:0] u_reg, u_next;
    logic [NUM_WIDTH-1:0] v_reg, v_next;
    logic [K_WIDTH-1:0]   k_reg, k_next;
    logic [DIV_WIDTH-1:0] g_reg;

    logic [NUM_WIDTH:0]   u_minus_v;
    logic [NUM_WIDTH:0]   v_minus_u;
    logic [NUM_WIDTH-1:0] g_wide;
    logic                 equal;

    assign u_minus_v = {1'b0, u_reg} - {1'b0, v_reg};
    assign v_minus_u = {1'b0, v_reg} - {1'b0, u_reg};
    assign equal     = (u_reg == v_reg);
    assign g_wide    = u_reg << k_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        if (start)
        begin
            busy_next = 1'b1;
            u_next    = x;
            v_next    = y;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            if (equal)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                // common factor of two: count it
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + K_WIDTH'(1);
            end
            else if (!u_reg[0])
            begin
                u_next = u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
            end
            else if (u_minus_v[NUM_WIDTH])
            begin
                v_next = {1'b0, v_minus_u[NUM_WIDTH-1:1]};
            end
            else
            begin
                u_next = {1'b0, u_minus_v[NUM_WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
        if (busy_reg && equal)
        begin
            g_reg <= g_wide[DIV_WIDTH-1:0];
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

// ===== hw/rtl/fraction_arith_reduce_top.sv =====
`timescale 1ns / 1ps
// Top level: fraction add, subtract or multiply with whole-part split and reduction.
//
// Usage
//   operand: valid/ready channel carrying op and the fractions a_num/a_den,
//            b_num/b_den. A transfer happens on a rising edge with valid and
//            ready both high. ready is high only while no item is in work.
//   result:  valid/ready channel carrying whole_part, frac_num, frac_den.
//            The result sits in an output register until its transfer, and
//            the next operand may be taken while it waits.
// Sequence (NW = 2*max(FRACTION_WIDTH,16)+1, 33 by default)
//   The states MUL1, MUL2 and MUL3 use the shared multiplier, then come a sum
//   and a check state, the bit-serial divider for the whole part (NW-bit
//   dividend, run only if the numerator is at least the denominator), the
//   binary gcd if a remainder is left, and two more divider passes by the gcd.
//   Zero numerators and zero denominators go from the check state straight to
//   the result state. The sequencer returns to idle before the next transfer;
//   one item is in work at once.
// Reset: rst_n clears the sequencer, the unit controls and the result valid flag.
// Stall: if result.ready is low, a finished item waits in its last state until
//   the output register frees; nothing is dropped or overwritten.
module fraction_arith_reduce_top
    import fra_pkg::*;
#(
    parameter int FRACTION_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    fra_in_if.sink    operand,
    fra_out_if.source result
);

    localparam int OPND_WIDTH = (FRACTION_WIDTH > DEN_WIDTH + 1) ? FRACTION_WIDTH
                                                                 : DEN_WIDTH + 1;
    localparam int NUM_WIDTH  = 2 * OPND_WIDTH + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MUL1  = 11'b000_0000_0010,
        S_MUL2  = 11'b000_0000_0100,
        S_MUL3  = 11'b000_0000_1000,
        S_SUM   = 11'b000_0001_0000,
        S_CHECK = 11'b000_0010_0000,
        S_DIVQ  = 11'b000_0100_0000,
        S_GCD   = 11'b000_1000_0000,
        S_DIVN  = 11'b001_0000_0000,
        S_DIVD  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // latched operands
    logic [OP_WIDTH-1:0]              op_reg;
    logic signed [FRACTION_WIDTH-1:0] an_reg;
    logic [DEN_WIDTH-1:0]             ad_reg;
    logic signed [FRACTION_WIDTH-1:0] bn_reg;
    logic [DEN_WIDTH-1:0]             bd_reg;

    // working values
    logic signed [2*OPND_WIDTH-1:0]   p1_reg;
    logic signed [2*OPND_WIDTH-1:0]   p2_reg;
    logic signed [NUM_WIDTH-1:0]      n_reg, n_next;
    logic [PROD_WIDTH-1:0]            d_reg;
    logic [NUM_WIDTH-1:0]             x_reg;
    logic                             neg_reg;
    logic [NUM_WIDTH-1:0]             whole_reg;
    logic [NUM_WIDTH-1:0]             fn_reg;
    logic [PROD_WIDTH-1:0]            fd_reg;

    // output register
    logic                             out_valid_reg, out_valid_next;
    logic [WHOLE_WIDTH-1:0]           out_whole_reg;
    logic signed [FNUM_WIDTH-1:0]     out_fnum_reg;
    logic [PROD_WIDTH-1:0]            out_fden_reg;

    // shared unit hookup
    logic signed [OPND_WIDTH-1:0]     mul_a, mul_b;
    logic signed [2*OPND_WIDTH-1:0]   product;
    logic                             div_start, div_done;
    logic [NUM_WIDTH-1:0]             div_dividend, div_quotient;
    logic [PROD_WIDTH-1:0]            div_divisor, div_remainder;
    logic                             gcd_start, gcd_done;
    logic [NUM_WIDTH-1:0]             gcd_x, gcd_y;
    logic [PROD_WIDTH-1:0]            gcd_g;

    logic                             in_xfer;
    logic                             out_free;
    logic                             den_zero;
    logic [NUM_WIDTH-1:0]             n_mag;
    logic [NUM_WIDTH-1:0]             d_wide;
    logic [NUM_WIDTH-1:0]             rem_wide;
    logic [NUM_WIDTH-1:0]             fn_signed;

    assign operand.ready = (state_reg == S_IDLE);
    assign in_xfer       = operand.valid && operand.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign den_zero      = (ad_reg == '0) || (bd_reg == '0);
    assign n_mag         = n_reg[NUM_WIDTH-1] ? NUM_WIDTH'(-n_reg) : NUM_WIDTH'(n_reg);
    assign d_wide        = NUM_WIDTH'(d_reg);
    assign rem_wide      = NUM_WIDTH'(div_remainder);
    assign fn_signed     = neg_reg ? (~div_quotient + NUM_WIDTH'(1)) : div_quotient;

    fra_mul #(
        .OPND_WIDTH (OPND_WIDTH)
    ) u_mul (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    fra_div #(
        .NUM_WIDTH (NUM_WIDTH),
        .DIV_WIDTH (PROD_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    fra_gcd #(
        .NUM_WIDTH (NUM_WIDTH),
        .DIV_WIDTH (PROD_WIDTH)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (gcd_x),
        .y     (gcd_y),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    // multiplier operand select: numerator products first, then the denominators
    always_comb
    begin
        mul_a = OPND_WIDTH'(ad_reg);
        mul_b = OPND_WIDTH'(bd_reg);
        unique case (state_reg)
            S_MUL1:
            begin
                mul_a = OPND_WIDTH'(an_reg);
                if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    mul_b = OPND_WIDTH'(bd_reg);
                end
                else
                begin
                    mul_b = OPND_WIDTH'(bn_reg);
                end
            end
            S_MUL2:
            begin
                mul_a = OPND_WIDTH'(ad_reg);
                mul_b = OPND_WIDTH'(bn_reg);
            end
            default:
            begin
                mul_a = OPND_WIDTH'(ad_reg);
                mul_b = OPND_WIDTH'(bd_reg);
            end
        endcase
    end

    // combine the cross products; unused op code behaves as multiply
    always_comb
    begin
        case (op_reg)
            OP_ADD:  n_next = NUM_WIDTH'(p1_reg) + NUM_WIDTH'(p2_reg);
            OP_SUB:  n_next = NUM_WIDTH'(p1_reg) - NUM_WIDTH'(p2_reg);
            default: n_next = NUM_WIDTH'(p1_reg);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        div_dividend   = n_reg;
        div_divisor    = d_reg;
        gcd_start      = 1'b0;
        gcd_x          = n_mag;
        gcd_y          = d_wide;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (den_zero || n_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (n_reg >= $signed(d_wide))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVQ;
                end
                else
                begin
                    gcd_start  = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_DIVQ:
            begin
                gcd_x = rem_wide;
                if (div_done)
                begin
                    if (div_remainder == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        gcd_start  = 1'b1;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                div_dividend = x_reg;
                div_divisor  = gcd_g;
                if (gcd_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                div_dividend = d_wide;
                div_divisor  = gcd_g;
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold here until the output register frees
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg <= operand.op;
            an_reg <= operand.a_num;
            ad_reg <= operand.a_den;
            bn_reg <= operand.b_num;
            bd_reg <= operand.b_den;
        end

        if (state_reg == S_MUL2)
        begin
            p1_reg <= product;
        end
        if (state_reg == S_MUL3)
        begin
            p2_reg <= product;
        end
        if (state_reg == S_SUM)
        begin
            n_reg <= n_next;
            d_reg <= product[PROD_WIDTH-1:0];
        end

        if (state_reg == S_CHECK)
        begin
            neg_reg   <= n_reg[NUM_WIDTH-1];
            x_reg     <= n_mag;
            whole_reg <= '0;
            fn_reg    <= '0;
            // a zero denominator flags itself with a zero result denominator
            fd_reg    <= den_zero ? '0 : PROD_WIDTH'(1);
        end
        if (state_reg == S_DIVQ && div_done)
        begin
            whole_reg <= div_quotient;
            x_reg     <= rem_wide;
            neg_reg   <= 1'b0;
        end
        if (state_reg == S_DIVN && div_done)
        begin
            fn_reg <= fn_signed;
        end
        if (state_reg == S_DIVD && div_done)
        begin
            fd_reg <= div_quotient[PROD_WIDTH-1:0];
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_whole_reg <= whole_reg[WHOLE_WIDTH-1:0];
            out_fnum_reg  <= fn_reg[FNUM_WIDTH-1:0];
            out_fden_reg  <= fd_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.whole_part = out_whole_reg;
    assign result.frac_num   = out_fnum_reg;
    assign result.frac_den   = out_fden_reg;

    // one item in work at a time: a transfer closes the operand channel
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !operand.ready)
        else $error("operand channel still open after a transfer");

    // the gcd of two nonzero values is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        gcd_done |-> gcd_g != '0)
        else $error("gcd unit returned zero");

    // a zero result denominator only ever marks the error result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frac_den == '0) |->
            (result.whole_part == '0 && result.frac_num == '0))
        else $error("zero denominator with nonzero result fields");

    // nothing left over means the remaining fraction reads 0/1
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frac_num == '0 && result.frac_den != '0) |->
            result.frac_den == PROD_WIDTH'(1))
        else $error("empty remainder not reduced to 0/1");

endmodule
